@@ rtl/hsr_pkg.sv @@
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared types and constants of the hit strip rasterizer.
// ----------------------------------------------------------------------------
package hsr_pkg;

   localparam logic [2:0] CSR_CENTER_X    = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [2:0] CSR_HALF_EXTENT = 3'd2;
   localparam logic [2:0] CSR_BIN_PITCH   = 3'd3;
   localparam logic [2:0] CSR_ENERGY_SUM  = 3'd4;

   localparam int IDX_W = 8;

   typedef struct packed {
      logic [2:0]         layer;
      logic signed [15:0] hit_x;
      logic signed [15:0] hit_y;
      logic [23:0]        hit_energy;
   } req_type;

   typedef struct packed {
      logic [6:0]  cell_col;
      logic [6:0]  cell_row;
      logic [2:0]  cell_layer;
      logic [15:0] cell_value;
      logic        in_range;
      logic        last_cell;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [14:0]        half_extent;
      logic [14:0]        bin_pitch;
      logic [23:0]        energy_sum;
   } cfg_type;

   typedef struct packed {
      logic [2:0]       layer;
      logic             odd;
      logic [IDX_W-1:0] fixed_idx;
      logic [IDX_W-1:0] lo_idx;
      logic [2:0]       span;
      logic [15:0]      value;
      logic             in_range;
   } job_type;

endpackage

@@ rtl/hsr_front.sv @@
// ----------------------------------------------------------------------------
// hsr_front
// Accepts hits, divides by pitch and energy sum, clips the strip to the grid.
// ----------------------------------------------------------------------------
module hsr_front #(
   parameter int GRID_SIZE   = 65,
   parameter int LAYER_COUNT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  hsr_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsr_pkg::req_type req_data,
   output logic             job_valid,
   input  logic             job_full,
   output hsr_pkg::job_type job_data
);
   import hsr_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;
   localparam logic [4:0] DIV_LAST = 5'd20;
   localparam logic [4:0] ENERGY_STEPS = 5'd16;
   localparam logic signed [21:0] GRID_MAX = 22'(GRID_SIZE - 1);

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   req_type     hit_ff;
   logic [15:0] dfix_ff, dspan_ff;
   logic [20:0] nmag_ff [3];
   logic        nneg_ff [3];
   logic [15:0] rem_ff  [3];
   logic [20:0] quo_ff  [3];
   logic [23:0] erem_ff;
   logic [15:0] equo_ff;
   logic        esat_ff;
   logic signed [21:0] qs_ff [3];
   logic [15:0] value_ff;

   // prep arithmetic
   logic [14:0] pitch;
   logic signed [17:0] vx, vy, vfix, vspan;
   logic signed [19:0] seven_p, n_lo, n_hi;
   logic signed [20:0] n_s [3];

   always_comb begin
      pitch   = (cfg.bin_pitch == 15'd0) ? 15'd1 : cfg.bin_pitch;
      vx      = 18'(hit_ff.hit_x) - 18'(cfg.center_x) + 18'({1'b0, cfg.half_extent});
      vy      = 18'(hit_ff.hit_y) - 18'(cfg.center_y) + 18'({1'b0, cfg.half_extent});
      vfix    = hit_ff.layer[0] ? vy : vx;
      vspan   = hit_ff.layer[0] ? vx : vy;
      seven_p = 20'({pitch, 3'b000}) - 20'(pitch);
      n_lo    = $signed({vspan, 1'b0}) - seven_p;
      n_hi    = $signed({vspan, 1'b0}) + seven_p;
      n_s[0]  = 21'(vfix);
      n_s[1]  = 21'(n_lo);
      n_s[2]  = 21'(n_hi);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_PREP;
         ST_PREP: begin
            state_in = ST_DIV;
            cnt_in   = 5'd0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) state_in = ST_FIX;
         end
         ST_FIX:  state_in = ST_PUSH;
         ST_PUSH: if (!job_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   logic [16:0] t   [3];
   logic [15:0] dsel[3];
   logic [24:0] et;

   always_comb begin
      dsel[0] = dfix_ff;
      dsel[1] = dspan_ff;
      dsel[2] = dspan_ff;
      for (int k = 0; k < 3; k++) t[k] = {rem_ff[k], nmag_ff[k][20]};
      et = {erem_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) hit_ff <= req_data;
      if (state_ff == ST_PREP) begin
         dfix_ff  <= {1'b0, pitch};
         dspan_ff <= {pitch, 1'b0};
         for (int k = 0; k < 3; k++) begin
            nneg_ff[k] <= n_s[k][20];
            nmag_ff[k] <= n_s[k][20] ? 21'(-n_s[k]) : 21'(n_s[k]);
            rem_ff[k]  <= 16'd0;
            quo_ff[k]  <= 21'd0;
         end
         erem_ff <= hit_ff.hit_energy;
         equo_ff <= 16'd0;
         esat_ff <= (cfg.energy_sum == 24'd0) || (hit_ff.hit_energy >= cfg.energy_sum);
      end
      if (state_ff == ST_DIV) begin
         for (int k = 0; k < 3; k++) begin
            nmag_ff[k] <= {nmag_ff[k][19:0], 1'b0};
            if (t[k] >= {1'b0, dsel[k]}) begin
               rem_ff[k] <= 16'(t[k] - {1'b0, dsel[k]});
               quo_ff[k] <= {quo_ff[k][19:0], 1'b1};
            end else begin
               rem_ff[k] <= t[k][15:0];
               quo_ff[k] <= {quo_ff[k][19:0], 1'b0};
            end
         end
         if (cnt_ff < ENERGY_STEPS) begin
            if (et >= {1'b0, cfg.energy_sum}) begin
               erem_ff <= 24'(et - {1'b0, cfg.energy_sum});
               equo_ff <= {equo_ff[14:0], 1'b1};
            end else begin
               erem_ff <= et[23:0];
               equo_ff <= {equo_ff[14:0], 1'b0};
            end
         end
      end
      if (state_ff == ST_FIX) begin
         // truncate toward zero: apply the sign after the magnitude divide
         for (int k = 0; k < 3; k++)
            qs_ff[k] <= nneg_ff[k] ? -$signed({1'b0, quo_ff[k]}) : $signed({1'b0, quo_ff[k]});
         value_ff <= esat_ff ? 16'hFFFF : equo_ff;
      end
   end

   logic signed [21:0] lo_c, hi_c, diff;
   logic fix_ok, layer_ok, ok;

   always_comb begin
      lo_c     = (qs_ff[1] < 0) ? 22'sd0 : qs_ff[1];
      hi_c     = (qs_ff[2] > GRID_MAX) ? GRID_MAX : qs_ff[2];
      diff     = hi_c - lo_c;
      fix_ok   = (qs_ff[0] >= 0) && (qs_ff[0] <= GRID_MAX);
      layer_ok = {1'b0, hit_ff.layer} < 4'(LAYER_COUNT);
      ok       = fix_ok && layer_ok && (diff >= 0);
      job_data.layer     = hit_ff.layer;
      job_data.odd       = hit_ff.layer[0];
      job_data.fixed_idx = ok ? qs_ff[0][IDX_W-1:0] : '0;
      job_data.lo_idx    = ok ? lo_c[IDX_W-1:0] : '0;
      job_data.span      = !ok ? 3'd0 : (diff > 22'sd7) ? 3'd7 : diff[2:0];
      job_data.value     = ok ? value_ff : 16'd0;
      job_data.in_range  = ok;
   end

   assign job_valid = (state_ff == ST_PUSH);
   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ rtl/hsr_queue.sv @@
// ----------------------------------------------------------------------------
// hsr_queue
// Two-entry job queue between the front and back halves.
// ----------------------------------------------------------------------------
module hsr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hsr_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output hsr_pkg::job_type head_data
);
   import hsr_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop)  rd_ff <= !rd_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ff != rd_ff))
      else $error("queue pointers disagree with count");
   a_ptr_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ff == rd_ff))
      else $error("queue pointers apart while empty");
`endif

endmodule

@@ rtl/hsr_back.sv @@
// ----------------------------------------------------------------------------
// hsr_back
// Walks each job's strip and drives one cell word per cycle while not stalled.
// ----------------------------------------------------------------------------
module hsr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  hsr_pkg::job_type job_data,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsr_pkg::rsp_type rsp_data
);
   import hsr_pkg::*;

   logic [2:0]       k_ff;
   logic             valid_ff;
   rsp_type          out_ff;
   logic             load, last;
   logic [IDX_W-1:0] idx;

   assign load    = job_valid && (!valid_ff || !rsp_stall);
   assign last    = (k_ff == job_data.span);
   assign idx     = job_data.lo_idx + IDX_W'(k_ff);
   assign job_pop = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            k_ff     <= last ? 3'd0 : k_ff + 3'd1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.cell_col   <= job_data.odd ? idx[6:0] : job_data.fixed_idx[6:0];
         out_ff.cell_row   <= job_data.odd ? job_data.fixed_idx[6:0] : idx[6:0];
         out_ff.cell_layer <= job_data.layer;
         out_ff.cell_value <= job_data.value;
         out_ff.in_range   <= job_data.in_range;
         out_ff.last_cell  <= last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ff.in_range) |-> out_ff.last_cell)
      else $error("off-grid word not marked last");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ff.in_range) |-> (out_ff.cell_value == 16'd0))
      else $error("off-grid word carries a value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled word changed");
`endif

endmodule

@@ rtl/hit_strip_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// hit_strip_rasterizer_core
// Rasterizes detector hits as short strips of cell writes over a square grid.
// ----------------------------------------------------------------------------
// channel  direction  handshake          word
// req_     in         req_valid/stall    layer, hit_x, hit_y, hit_energy
// rsp_     out        rsp_valid/stall    cell_col/row/layer/value, in_range, last
// csr_     in         csr_valid/ready    csr_index, csr_wdata
//
// The front takes one hit at a time: load, prep, 21 divide steps for the pitch
// (energy-sum divide alongside), fix-up and push. The back drives one word per
// cycle unless stalled, 1 to 8 per hit, from a two-entry job queue, so both
// halves overlap. Synchronous reset restores config (pitch 256, sum 1).
// rsp_stall holds the output word; req_stall rises while the front is busy.
// ----------------------------------------------------------------------------
module hit_strip_rasterizer_core #(
   parameter int GRID_SIZE   = 65,
   parameter int LAYER_COUNT = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   import hsr_pkg::*;

   cfg_type cfg_ff;
   logic    job_push, job_full, head_valid, job_pop;
   job_type push_data, head_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= 16'sd0;
         cfg_ff.center_y    <= 16'sd0;
         cfg_ff.half_extent <= 15'd0;
         cfg_ff.bin_pitch   <= 15'd256;
         cfg_ff.energy_sum  <= 24'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X:    cfg_ff.center_x    <= csr_wdata[15:0];
            CSR_CENTER_Y:    cfg_ff.center_y    <= csr_wdata[15:0];
            CSR_HALF_EXTENT: cfg_ff.half_extent <= csr_wdata[14:0];
            CSR_BIN_PITCH:   cfg_ff.bin_pitch   <= csr_wdata[14:0];
            CSR_ENERGY_SUM:  cfg_ff.energy_sum  <= csr_wdata;
            default: ;
         endcase
      end
   end

   hsr_front #(.GRID_SIZE(GRID_SIZE), .LAYER_COUNT(LAYER_COUNT)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .job_valid(job_push), .job_full(job_full), .job_data(push_data)
   );

   hsr_queue u_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .push_data(push_data), .full(job_full),
      .pop(job_pop), .head_valid(head_valid), .head_data(head_data)
   );

   hsr_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(head_valid), .job_data(head_data), .job_pop(job_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule
